FILE: sv/zbp_pkg.sv
// ----------------------------------------------------------------------------
// zbp_pkg
// Shared types and constants of the zigzag bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package zbp_pkg;

    localparam int VAL_W   = 64;   // width of values and bound registers
    localparam int BYTE_W  = 8;
    localparam int WID_W   = 7;    // packed width, 1..64
    localparam int PEND_W  = 3;    // bits held toward the next byte, 0..7
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] min_value;
        logic signed [VAL_W-1:0] max_value;
    } t_cfg;

    // one classified value travelling from front to back
    typedef struct packed {
        logic [VAL_W-1:0] value;   // sign extended, zigzag mapped while min is negative
        logic [WID_W-1:0] width;   // width of the run, used on its first word
        logic             first;
        logic             last;
    } t_item;

endpackage

`default_nettype wire

FILE: sv/zbp_in_if.sv
// ----------------------------------------------------------------------------
// zbp_in_if
// Input channel: one signed value of a run and its end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface zbp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/zbp_out_if.sv
// ----------------------------------------------------------------------------
// zbp_out_if
// Output channel: one byte of the packed stream and its end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface zbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: sv/zbp_front.sv
// ----------------------------------------------------------------------------
// zbp_front
// Accepts values, applies sign extension and zigzag mapping, and works out
// the packed width from the bounds over two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module zbp_front #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire zbp_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [63:0]   i_value,
    input  wire logic          i_last,
    output logic               o_valid,
    input  wire logic          i_ready,
    output zbp_pkg::t_item     o_item
);
    import zbp_pkg::*;

    localparam logic [VAL_W-1:0] VMASK = (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}}
                                       : ((64'd1 << VALUE_BITS) - 64'd1);
    localparam int NGRP = VAL_W / BYTE_W;

    function automatic logic [2:0] msb3(input logic [BYTE_W-1:0] b);
        logic [2:0] p;
        p = 3'd0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) p = 3'(i);
        end
        return p;
    endfunction

    // stage 1
    logic             r_vld1, n_vld1;
    logic [VAL_W-1:0] r_val1, r_op1;
    logic             r_last1, r_first1;
    // stage 2
    logic             r_vld2, n_vld2;
    logic [VAL_W-1:0] r_val2;
    logic             r_last2, r_first2;
    logic [NGRP-1:0]  r_nz2;
    logic [2:0]       r_pos2 [NGRP];
    // run tracking
    logic             r_first;

    logic             adv1, adv2, rdy2;
    logic [VAL_W-1:0] sext, zval, zmin, op;

    assign rdy2    = !r_vld2 || i_ready;
    assign o_ready = !r_vld1 || rdy2;
    assign adv1    = i_valid && o_ready;
    assign adv2    = r_vld1 && rdy2;

    always_comb begin
        sext = i_value[VALUE_BITS-1] ? (i_value | ~VMASK) : (i_value & VMASK);
        zval = i_cfg.min_value[VAL_W-1] ? ((sext << 1) ^ {VAL_W{sext[VAL_W-1]}}) : sext;
        // zigzag image of min is -2*min - 1, i.e. the complement of 2*min
        zmin = ~(i_cfg.min_value << 1);
        if (!i_cfg.min_value[VAL_W-1]) begin
            op = i_cfg.max_value;
        end else if (i_cfg.max_value[VAL_W-1]) begin
            op = zmin;
        end else begin
            // bit length of an OR is the larger of the two lengths
            op = zmin | (i_cfg.max_value << 1);
        end
    end

    always_comb begin
        n_vld1 = r_vld1;
        if (adv1) n_vld1 = 1'b1;
        else if (adv2) n_vld1 = 1'b0;
        n_vld2 = r_vld2;
        if (adv2) n_vld2 = 1'b1;
        else if (i_ready) n_vld2 = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
            r_first <= 1'b1;
        end else begin
            r_vld1 <= n_vld1;
            r_vld2 <= n_vld2;
            if (adv1) r_first <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_val1   <= zval;
            r_op1    <= op;
            r_last1  <= i_last;
            r_first1 <= r_first;
        end
        if (adv2) begin
            r_val2   <= r_val1;
            r_last2  <= r_last1;
            r_first2 <= r_first1;
            for (int g = 0; g < NGRP; g++) begin
                r_nz2[g]  <= |r_op1[g*BYTE_W +: BYTE_W];
                r_pos2[g] <= msb3(r_op1[g*BYTE_W +: BYTE_W]);
            end
        end
    end

    always_comb begin
        o_item.width = WID_W'(1);
        for (int g = 0; g < NGRP; g++) begin
            if (r_nz2[g]) o_item.width = WID_W'({3'(g), r_pos2[g]}) + WID_W'(1);
        end
        o_item.value = r_val2;
        o_item.first = r_first2;
        o_item.last  = r_last2;
    end

    assign o_valid = r_vld2;

endmodule

`default_nettype wire

FILE: sv/zbp_fifo.sv
// ----------------------------------------------------------------------------
// zbp_fifo
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module zbp_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire zbp_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output zbp_pkg::t_item      o_item
);
    import zbp_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_item;
    end

endmodule

`default_nettype wire

FILE: sv/zbp_back.sv
// ----------------------------------------------------------------------------
// zbp_back
// Bit packer: emits the header, appends value bits MSB first into the byte
// accumulator and flushes the partial byte at the end of a run.
// ----------------------------------------------------------------------------
`default_nettype none

module zbp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire zbp_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);
    import zbp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HDR   = 4'b0010,
        ST_BITS  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [BYTE_W-1:0]   r_acc, n_acc;
    logic [PEND_W-1:0]   r_pend, n_pend;
    logic [WID_W-1:0]    r_width, n_width;
    logic [WID_W-1:0]    r_rem, n_rem;
    logic [VAL_W-1:0]    r_sh, n_sh;
    logic                r_last, n_last;
    logic                r_ov, n_ov;
    logic [BYTE_W-1:0]   r_ob, n_ob;
    logic                r_ol, n_ol;

    logic                out_free;
    logic [WID_W-1:0]    ld_width;
    logic [3:0]          room, k, pend_sum;
    logic [2*BYTE_W-1:0] tmp;
    logic [WID_W-1:0]    rem_left;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign ld_width = i_item.first ? i_item.width : r_width;

    always_comb begin
        room     = 4'd8 - {1'b0, r_pend};
        k        = (r_rem < {3'b0, room}) ? r_rem[3:0] : room;
        tmp      = {r_acc, r_sh[VAL_W-1 -: BYTE_W]} << k;
        pend_sum = {1'b0, r_pend} + k;
        rem_left = r_rem - {3'b0, k};
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_width = r_width;
        n_rem   = r_rem;
        n_sh    = r_sh;
        n_last  = r_last;
        n_ov    = r_ov && !i_ready;
        n_ob    = r_ob;
        n_ol    = r_ol;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_width = ld_width;
                    n_rem   = ld_width;
                    // left-align so the first bit to send sits at the top
                    n_sh    = i_item.value << 6'(7'd64 - ld_width);
                    n_last  = i_item.last;
                    n_state = i_item.first ? ST_HDR : ST_BITS;
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ob    = BYTE_W'(r_width);
                    n_ol    = 1'b0;
                    n_state = ST_BITS;
                end
            end
            ST_BITS: begin
                if (out_free) begin
                    n_sh  = r_sh << k;
                    n_rem = rem_left;
                    if (pend_sum == 4'd8) begin
                        n_ov   = 1'b1;
                        n_ob   = tmp[2*BYTE_W-1:BYTE_W];
                        n_ol   = r_last && (rem_left == '0);
                        n_acc  = '0;
                        n_pend = '0;
                    end else begin
                        n_acc  = tmp[2*BYTE_W-1:BYTE_W];
                        n_pend = pend_sum[PEND_W-1:0];
                    end
                    if (rem_left == '0) begin
                        if (r_last && pend_sum != 4'd8) n_state = ST_FLUSH;
                        else                            n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ob    = r_acc << (4'd8 - {1'b0, r_pend});
                    n_ol    = 1'b1;
                    n_acc   = '0;
                    n_pend  = '0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc   <= '0;
            r_pend  <= '0;
            r_width <= WID_W'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_width <= n_width;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_sh   <= n_sh;
        r_last <= n_last;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;

endmodule

`default_nettype wire

FILE: sv/zigzag_bit_packer.sv
// ----------------------------------------------------------------------------
// zigzag_bit_packer
// Packs runs of signed values into a byte stream at one width per run.
// ----------------------------------------------------------------------------
// The first word of a run emits a header byte holding the packed width
// (1..64), taken from min_value and max_value at that word. Each value is
// zigzag mapped while min_value is negative, cut to the width and sent MSB
// first. The word marked last flushes any zero-padded partial byte, and
// out_last is set on the final byte of the run. The front takes one word
// per cycle, unless held by back-pressure, through two pipeline stages
// into a two-word queue, so four words go in back to back before the back
// has to keep pace. The back loads a word in its idle state, then emits
// the header on the first word of a run, then packs in steps and, on the
// last word, flushes any partial byte. It does ceil((held + width) / 8)
// packing steps, where held is the 0..7 bits already waiting. The back
// takes no new word before it is done with the last. An output stall holds
// it, since every byte waits in the single output register. The user must
// write bounds through the cfg port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module zigzag_bit_packer #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    zbp_in_if.sink                             i_in,
    zbp_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [zbp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [zbp_pkg::VAL_W-1:0]     i_cfg_data
);
    import zbp_pkg::*;

    t_cfg  r_cfg;
    t_item f_item, q_item;
    logic  f_valid, f_ready, q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_VALUE: r_cfg.min_value <= i_cfg_data;
                CFG_MAX_VALUE: r_cfg.max_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    zbp_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_value (i_in.value),
        .i_last  (i_in.last),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    zbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    zbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_byte  (o_out.out_byte),
        .o_last  (o_out.out_last)
    );

endmodule

`default_nettype wire

FILE: sv/zbp_checker.sv
// ----------------------------------------------------------------------------
// zbp_checker
// Port-level checks on the packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module zbp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);
    // set while the next byte to appear must be a header
    logic r_exp_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_hdr <= 1'b1;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_hdr <= i_out_last;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_exp_hdr |-> (i_out_byte != 8'd0) && (i_out_byte <= 8'd64)
                                     && !i_out_last)
        else $error("header byte out of range");

endmodule

bind zigzag_bit_packer zbp_checker u_zbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the zigzag bit packer: runs of signed words are
// driven under several bound settings and idling patterns, and every packed
// byte is compared against an in-bench predictor of the packed stream.
// ----------------------------------------------------------------------------

module testbench;

    localparam int          CLK_PERIOD   = 8;
    localparam int          RESET_CYCLES = 8;
    localparam int          DRAIN_CYCLES = 40;   // covers the front path and one word
    localparam int          PHASE_WORDS  = 125;
    // limit for the whole run, meant to be far above its worst case
    localparam int          TIMEOUT_NS   = 4_000_000;
    localparam logic [63:0] MOST_NEG     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES     = '1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_packed_byte;

    // Predicts the packed byte stream word by word.
    class t_packed_stream_model;
        logic signed [63:0] min_bound;
        logic signed [63:0] max_bound;
        logic [7:0]         acc;
        logic [2:0]         held_bits;
        bit                 header_done;
        logic [6:0]         run_width;
        t_packed_byte       step_bytes[$];
        t_packed_byte       expected_bytes[$];
        int                 errors;
        int                 bytes_seen;
        int                 runs_seen;

        function new();
            min_bound   = '0;
            max_bound   = '0;
            acc         = '0;
            held_bits   = '0;
            header_done = 1'b0;
            run_width   = 7'd1;
            errors      = 0;
            bytes_seen  = 0;
            runs_seen   = 0;
        endfunction

        function int unsigned bit_len(logic [63:0] x);
            for (int i = 63; i >= 0; i--) begin
                if (x[i]) return i + 1;
            end
            return 1;
        endfunction

        function logic [6:0] bounds_width();
            logic [63:0] umin;
            logic [63:0] umax;
            int unsigned from_min;
            int unsigned from_max;
            umin = min_bound;
            umax = max_bound;
            if (min_bound == 0 && max_bound == 0) return 7'd1;
            if (min_bound < 0) begin
                // zigzag image of a negative bound is 2*|v| - 1
                from_min = bit_len(((64'd0 - umin) << 1) - 64'd1);
                if (max_bound < 0) return from_min[6:0];
                from_max = bit_len(umax << 1);
                return (from_min > from_max) ? from_min[6:0] : from_max[6:0];
            end
            return 7'(bit_len(umax));
        endfunction

        function void append_bits(logic [63:0] bits, int count);
            t_packed_byte e;
            for (int i = count - 1; i >= 0; i--) begin
                acc = {acc[6:0], bits[i]};
                if (held_bits == 3'd7) begin
                    e.data = acc;
                    e.last = 1'b0;
                    step_bytes.push_back(e);
                    acc       = '0;
                    held_bits = '0;
                end else begin
                    held_bits++;
                end
            end
        endfunction

        function void note_word(logic [63:0] raw, logic last_flag);
            logic [63:0]  v;
            t_packed_byte e;
            step_bytes.delete();
            if (!header_done) begin
                run_width = bounds_width();
                append_bits({57'd0, run_width}, 8);
                header_done = 1'b1;
            end
            v = raw;
            if (min_bound < 0) v = (raw << 1) ^ {64{raw[63]}};
            append_bits(v, int'(run_width));
            if (last_flag) begin
                if (held_bits != 3'd0) begin
                    e.data = acc << (8 - held_bits);
                    e.last = 1'b0;
                    step_bytes.push_back(e);
                    acc       = '0;
                    held_bits = '0;
                end
                if (step_bytes.size() > 0) begin
                    e = step_bytes.pop_back();
                    e.last = 1'b1;
                    step_bytes.push_back(e);
                end
                header_done = 1'b0;
                runs_seen++;
            end
            foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
        endfunction

        function void check_byte(logic [7:0] data, logic last_flag);
            t_packed_byte e;
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte: out_byte %h out_last %b", data, last_flag);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (data !== e.data) begin
                $error("out_byte mismatch: expected %h, actual %h", e.data, data);
                errors++;
            end
            if (last_flag !== e.last) begin
                $error("out_last mismatch: expected %b, actual %b", e.last, last_flag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [zbp_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [zbp_pkg::VAL_W-1:0]     cfg_data;

    zbp_in_if  in_ch();
    zbp_out_if out_ch();

    zigzag_bit_packer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_packed_stream_model stream;
    int in_gap_pct;
    int out_stall_pct;
    int words_sent;
    int bound_settings;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) stream.note_word(in_ch.value, in_ch.last);
            if (out_ch.valid && out_ch.ready) stream.check_byte(out_ch.out_byte, out_ch.out_last);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_bits(int w);
        if (w <= 0) return '0;
        if (w >= 64) return rand64();
        return rand64() & ((64'd1 << w) - 64'd1);
    endfunction

    // mostly in-bound values, with the bounds themselves and some noise
    function automatic logic [63:0] pick_value();
        logic [63:0] span;
        logic [63:0] r;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) return stream.min_bound;
        if (sel < 20) return stream.max_bound;
        if (sel < 85 && stream.min_bound <= stream.max_bound) begin
            span = stream.max_bound - stream.min_bound;
            r    = rand64();
            if (span != ALL_ONES) r = r % (span + 64'd1);
            return stream.min_bound + r;
        end
        if (sel < 93) return rand_bits($urandom_range(0, 64));
        return rand64();
    endfunction

    task automatic pick_bounds(output logic [63:0] lo, output logic [63:0] hi);
        logic [63:0] a;
        logic [63:0] b;
        int          w;
        w = $urandom_range(1, 64);
        a = rand_bits(w);
        b = rand_bits($urandom_range(0, w));
        case ($urandom_range(0, 7))
            0: begin
                lo = '0;
                hi = '0;
            end
            1, 2: begin
                lo = ($urandom_range(0, 3) == 0) ? b : '0;
                hi = a;
            end
            3, 4: begin
                lo = ~a;
                hi = b;
            end
            5: begin
                lo = ~((a > b) ? a : b);
                hi = ~((a > b) ? b : a);
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: begin lo = MOST_NEG; hi = MOST_POS; end
                    1: begin lo = '0;       hi = ALL_ONES; end
                    2: begin lo = MOST_NEG; hi = ALL_ONES; end
                    default: begin lo = MOST_NEG; hi = '0; end
                endcase
            end
            default: begin
                lo = rand64();
                hi = rand64();
            end
        endcase
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (stream.pending() != 0) @(posedge i_clk);
        // a word may still be in flight without having produced a byte
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bounds(logic [63:0] lo, logic [63:0] hi);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= zbp_pkg::CFG_MIN_VALUE;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_idx  <= zbp_pkg::CFG_MAX_VALUE;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        stream.min_bound = lo;
        stream.max_bound = hi;
        bound_settings++;
    endtask

    // valid is left high on return so back-to-back words need no dip
    task automatic send_word(logic [63:0] v, logic last_flag);
        while ($urandom_range(0, 99) < in_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= last_flag;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic send_run(int len);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int k = 0; k < len; k++) begin
            // now and then new bounds mid run: width stays, zigzag follows
            if (k > 0 && $urandom_range(0, 15) == 0) begin
                pick_bounds(lo, hi);
                write_bounds(lo, hi);
            end
            send_word(pick_value(), k == len - 1);
        end
    endtask

    task automatic directed_checks();
        // reset bounds: width 1, oversized values cut to one bit
        send_word(64'd0, 1'b1);
        send_word(64'd1, 1'b0);
        send_word(ALL_ONES, 1'b1);
        write_bounds(64'd0, 64'd255);
        send_word(64'd0, 1'b0);
        send_word(64'd255, 1'b1);
        // zero bit length raised to one
        write_bounds(64'd5, 64'd0);
        send_word(64'd1, 1'b1);
        write_bounds(MOST_NEG, MOST_POS);
        send_word(MOST_NEG, 1'b0);
        send_word(MOST_POS, 1'b1);
        // negative max read as unsigned
        write_bounds(64'd0, ALL_ONES);
        send_word(ALL_ONES, 1'b1);
        send_word(64'd12345, 1'b1);
        write_bounds(ALL_ONES, ALL_ONES);
        send_word(ALL_ONES, 1'b0);
        send_word(ALL_ONES, 1'b1);
        // most negative min wraps to all ones
        write_bounds(MOST_NEG, ALL_ONES);
        send_word(MOST_NEG, 1'b1);
        // bounds changed mid run
        write_bounds(-64'sd4, 64'd3);
        send_word(-64'sd4, 1'b0);
        send_word(64'd3, 1'b0);
        write_bounds(64'd0, 64'd3);
        send_word(64'd5, 1'b0);
        send_word(64'd7, 1'b1);
        write_bounds(64'd0, 64'd15);
        send_word(64'h1234, 1'b1);
    endtask

    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        int          target;
        int          len;
        stream         = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = zbp_pkg::CFG_MIN_VALUE;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.last     = 1'b0;
        out_ch.ready   = 1'b0;
        in_gap_pct     = 22;
        out_stall_pct  = 54;
        words_sent     = 0;
        bound_settings = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin in_gap_pct = 22; out_stall_pct = 54; end
                1: begin in_gap_pct = 54; out_stall_pct = 22; end
                default: begin in_gap_pct = 0; out_stall_pct = 0; end
            endcase
            if (p == 0) directed_checks();
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                if ($urandom_range(0, 2) == 0) begin
                    pick_bounds(lo, hi);
                    write_bounds(lo, hi);
                end
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(1, 6);
                send_run(len);
            end
        end

        wait_idle();
        $display("covered %0d words in %0d runs over %0d bound settings",
                 words_sent, stream.runs_seen, bound_settings);
        $display("%0d packed bytes checked under three idling patterns", stream.bytes_seen);
        if (stream.errors == 0) begin
            $display("zigzag_bit_packer test passed");
        end else begin
            $display("zigzag_bit_packer test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("zigzag_bit_packer test failed");
        $finish;
    end

endmodule
